// ===== rtl/core/bra_pkg.sv =====
// Package for the block range allocator: field widths, status and operation
// codes, the segment table entry and the result record.
// No dependencies.
package bra_pkg;

   // Element counts and offsets
   localparam int LEN_W = 13;
   localparam int OFS_W = 12;
   localparam int STATUS_W = 3;

   localparam logic [LEN_W-1:0] MAX_ELEMENTS = 13'd4096;
   localparam logic [LEN_W-1:0] CAPACITY_RESET = 13'd4096;
   localparam int MAX_SEGMENTS_DEFAULT = 64;

   // Stream payload widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;

   // Operation codes
   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_SHRANK = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 3'd4;

   // One entry of the segment table
   typedef struct packed {
      logic             empty;
      logic [LEN_W-1:0] length;
      logic [OFS_W-1:0] start;
   } seg_entry_type;

   localparam int SEG_W = $bits(seg_entry_type);

   // One result item
   typedef struct packed {
      logic [LEN_W-1:0]    free_at_end;
      logic [LEN_W-1:0]    free_total;
      logic [LEN_W-1:0]    used_total;
      logic [OFS_W-1:0]    range_offset;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

// ===== rtl/core/bra_ram.sv =====
// Simple dual-port synchronous memory: one write port, one read port,
// read data registered. No dependencies.
module bra_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bra_ctrl.sv =====
// Sequencer of the block range allocator: walks the segment table and the
// free list held in two memories, and keeps the counters and the capacity.
// Depends on bra_pkg.
module bra_ctrl #(
   parameter int MAX_SEGMENTS = bra_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_we,
   input  logic [bra_pkg::LEN_W-1:0]        csr_wdata,
   // request
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_op,
   input  logic [bra_pkg::LEN_W-1:0]        req_count,
   input  logic [bra_pkg::OFS_W-1:0]        req_offset,
   // result
   output logic                             res_valid,
   input  logic                             res_ready,
   output bra_pkg::result_type              res,
   // segment table memory
   output logic                             seg_wr_en,
   output logic [$clog2(MAX_SEGMENTS)-1:0]  seg_wr_addr,
   output logic [bra_pkg::SEG_W-1:0]        seg_wr_data,
   output logic                             seg_rd_en,
   output logic [$clog2(MAX_SEGMENTS)-1:0]  seg_rd_addr,
   input  logic [bra_pkg::SEG_W-1:0]        seg_rd_data,
   // free list memory
   output logic                             fl_wr_en,
   output logic [$clog2(MAX_SEGMENTS)-1:0]  fl_wr_addr,
   output logic [bra_pkg::OFS_W-1:0]        fl_wr_data,
   output logic                             fl_rd_en,
   output logic [$clog2(MAX_SEGMENTS)-1:0]  fl_rd_addr,
   input  logic [bra_pkg::OFS_W-1:0]        fl_rd_data
);

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CW-1:0] SEG_LIMIT = CW'(MAX_SEGMENTS);
   localparam logic [CW-1:0] ONE = CW'(1);

   // Sequencer states
   localparam logic [5:0] ST_INIT      = 6'd0;
   localparam logic [5:0] ST_IDLE      = 6'd1;
   localparam logic [5:0] ST_CHECK     = 6'd2;
   localparam logic [5:0] ST_GROW      = 6'd3;
   localparam logic [5:0] ST_SRCH      = 6'd4;
   localparam logic [5:0] ST_SRCH_KEY  = 6'd5;
   localparam logic [5:0] ST_SRCH_TEST = 6'd6;
   localparam logic [5:0] ST_FALLBACK  = 6'd7;
   localparam logic [5:0] ST_SPLIT     = 6'd8;
   localparam logic [5:0] ST_SPLIT2    = 6'd9;
   localparam logic [5:0] ST_INS_RD    = 6'd10;
   localparam logic [5:0] ST_INS_WR    = 6'd11;
   localparam logic [5:0] ST_ALLOC_FIN = 6'd12;
   localparam logic [5:0] ST_REL_TEST  = 6'd13;
   localparam logic [5:0] ST_REL_PREV  = 6'd14;
   localparam logic [5:0] ST_NEXT_RD   = 6'd15;
   localparam logic [5:0] ST_NEXT      = 6'd16;
   localparam logic [5:0] ST_NEXT_FL   = 6'd17;
   localparam logic [5:0] ST_NEXT_RM   = 6'd18;
   localparam logic [5:0] ST_SELF      = 6'd19;
   localparam logic [5:0] ST_SELF_FL   = 6'd20;
   localparam logic [5:0] ST_REL_FIN   = 6'd21;
   localparam logic [5:0] ST_TAIL_RD   = 6'd22;
   localparam logic [5:0] ST_TAIL      = 6'd23;
   localparam logic [5:0] ST_DONE      = 6'd24;
   localparam logic [5:0] ST_SF_RD     = 6'd25;
   localparam logic [5:0] ST_SF_CMP    = 6'd26;
   localparam logic [5:0] ST_FF_RD     = 6'd27;
   localparam logic [5:0] ST_FF_CMP    = 6'd28;
   localparam logic [5:0] ST_SR_RD     = 6'd29;
   localparam logic [5:0] ST_SR_WR     = 6'd30;
   localparam logic [5:0] ST_FR_RD     = 6'd31;
   localparam logic [5:0] ST_FR_WR     = 6'd32;

   logic [5:0] state_ff, state_in, ret_ff, ret_in;
   logic [bra_pkg::LEN_W-1:0] cap_ff, cap_in;
   logic [CW-1:0] seg_total_ff, seg_total_in, fl_total_ff, fl_total_in;
   logic [bra_pkg::LEN_W-1:0] applied_ff, applied_in, used_ff, used_in, free_ff, free_in;
   logic [bra_pkg::LEN_W-1:0] cnt_ff, cnt_in, rcount_ff, rcount_in;
   logic [bra_pkg::OFS_W-1:0] key_ff, key_in;
   logic [CW-1:0] scan_ff, scan_in, pos_ff, pos_in, idx_ff, idx_in;
   logic [CW-1:0] f_ff, f_in, mv_ff, mv_in;
   logic hit_ff, hit_in, flhit_ff, flhit_in;
   logic [bra_pkg::OFS_W-1:0] ent_start_ff, ent_start_in, cur_start_ff, cur_start_in;
   logic [bra_pkg::LEN_W-1:0] ent_len_ff, ent_len_in, cur_len_ff, cur_len_in;
   logic ent_empty_ff, ent_empty_in;
   logic [bra_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [bra_pkg::OFS_W-1:0] offset_ff, offset_in;
   logic [bra_pkg::LEN_W-1:0] tail_ff, tail_in;

   bra_pkg::seg_entry_type seg_rd, seg_wr;
   logic [bra_pkg::LEN_W-1:0] eff_cap;
   logic [CW-1:0] last;
   logic [bra_pkg::LEN_W-1:0] start_sum;

   assign seg_rd = bra_pkg::seg_entry_type'(seg_rd_data);
   assign seg_wr_data = seg_wr;
   assign eff_cap = (cap_ff > bra_pkg::MAX_ELEMENTS) ? bra_pkg::MAX_ELEMENTS : cap_ff;
   assign last = seg_total_ff - ONE;
   assign start_sum = {1'b0, ent_start_ff} + cnt_ff;
   assign req_ready = (state_ff == ST_IDLE);

   assign res.status = status_ff;
   assign res.range_offset = offset_ff;
   assign res.used_total = used_ff;
   assign res.free_total = free_ff;
   assign res.free_at_end = tail_ff;

   // Next state and memory accesses
   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      cap_in = csr_we ? csr_wdata : cap_ff;
      seg_total_in = seg_total_ff;
      fl_total_in = fl_total_ff;
      applied_in = applied_ff;
      used_in = used_ff;
      free_in = free_ff;
      cnt_in = cnt_ff;
      rcount_in = rcount_ff;
      key_in = key_ff;
      scan_in = scan_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      f_in = f_ff;
      mv_in = mv_ff;
      hit_in = hit_ff;
      flhit_in = flhit_ff;
      ent_start_in = ent_start_ff;
      ent_len_in = ent_len_ff;
      ent_empty_in = ent_empty_ff;
      cur_start_in = cur_start_ff;
      cur_len_in = cur_len_ff;
      status_in = status_ff;
      offset_in = offset_ff;
      tail_in = tail_ff;
      res_valid = 1'b0;
      seg_wr_en = 1'b0;
      seg_wr_addr = '0;
      seg_wr = '0;
      seg_rd_en = 1'b0;
      seg_rd_addr = '0;
      fl_wr_en = 1'b0;
      fl_wr_addr = '0;
      fl_wr_data = '0;
      fl_rd_en = 1'b0;
      fl_rd_addr = '0;

      unique case (state_ff)
         // Lay down the single empty segment after reset
         ST_INIT: begin
            seg_wr_en = 1'b1;
            seg_wr = '{empty: 1'b1, length: applied_ff, start: '0};
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cnt_in = req_count;
               key_in = req_offset;
               offset_in = '0;
               status_in = bra_pkg::STATUS_OK;
               scan_in = '0;
               if (req_op == bra_pkg::OP_RELEASE) begin
                  ret_in = ST_REL_TEST;
                  state_in = ST_SF_RD;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         // Allocate: screen the request, fetch the tail if capacity grew
         ST_CHECK: begin
            if (cnt_ff == '0) begin
               status_in = bra_pkg::STATUS_INVALID;
               state_in = ST_TAIL_RD;
            end else if (eff_cap < applied_ff) begin
               status_in = bra_pkg::STATUS_SHRANK;
               state_in = ST_TAIL_RD;
            end else if (eff_cap > applied_ff) begin
               seg_rd_en = 1'b1;
               seg_rd_addr = last[IW-1:0];
               state_in = ST_GROW;
            end else begin
               f_in = '0;
               state_in = ST_SRCH;
            end
         end
         // Apply growth: extend an empty tail or append a new empty segment, or report a full table
         ST_GROW: begin
            if (seg_rd.empty) begin
               seg_wr_en = 1'b1;
               seg_wr_addr = last[IW-1:0];
               seg_wr = '{empty: 1'b1, length: seg_rd.length + (eff_cap - applied_ff),
                          start: seg_rd.start};
            end else if (seg_total_ff >= SEG_LIMIT) begin
               status_in = bra_pkg::STATUS_TABLE_FULL;
            end else begin
               seg_wr_en = 1'b1;
               seg_wr_addr = seg_total_ff[IW-1:0];
               seg_wr = '{empty: 1'b1, length: eff_cap - applied_ff,
                          start: applied_ff[bra_pkg::OFS_W-1:0]};
               seg_total_in = seg_total_ff + ONE;
            end
            if (seg_rd.empty || seg_total_ff < SEG_LIMIT) begin
               free_in = free_ff + (eff_cap - applied_ff);
               applied_in = eff_cap;
               f_in = '0;
               state_in = ST_SRCH;
            end else begin
               state_in = ST_TAIL_RD;
            end
         end
         // Walk the free list in insertion order
         ST_SRCH: begin
            if (f_ff >= fl_total_ff) begin
               seg_rd_en = 1'b1;
               seg_rd_addr = last[IW-1:0];
               state_in = ST_FALLBACK;
            end else begin
               fl_rd_en = 1'b1;
               fl_rd_addr = f_ff[IW-1:0];
               state_in = ST_SRCH_KEY;
            end
         end
         ST_SRCH_KEY: begin
            key_in = fl_rd_data;
            scan_in = '0;
            ret_in = ST_SRCH_TEST;
            state_in = ST_SF_RD;
         end
         ST_SRCH_TEST: begin
            if (hit_ff && ent_len_ff >= cnt_ff) begin
               pos_in = f_ff;
               flhit_in = 1'b1;
               state_in = ST_SPLIT;
            end else begin
               f_in = f_ff + ONE;
               state_in = ST_SRCH;
            end
         end
         // No free-list fit: try the trailing empty segment
         ST_FALLBACK: begin
            if (seg_rd.empty && seg_rd.length >= cnt_ff) begin
               idx_in = last;
               ent_start_in = seg_rd.start;
               ent_len_in = seg_rd.length;
               flhit_in = 1'b0;
               state_in = ST_SPLIT;
            end else begin
               status_in = bra_pkg::STATUS_NO_SPACE;
               state_in = ST_TAIL_RD;
            end
         end
         ST_SPLIT: begin
            if (ent_len_ff > cnt_ff && seg_total_ff >= SEG_LIMIT) begin
               status_in = bra_pkg::STATUS_TABLE_FULL;
               state_in = ST_TAIL_RD;
            end else if (flhit_ff) begin
               mv_in = pos_ff;
               ret_in = ST_SPLIT2;
               state_in = ST_FR_RD;
            end else begin
               state_in = ST_SPLIT2;
            end
         end
         ST_SPLIT2: begin
            mv_in = seg_total_ff;
            state_in = (ent_len_ff > cnt_ff) ? ST_INS_RD : ST_ALLOC_FIN;
         end
         // Open a slot after the chosen segment, then place the remainder
         ST_INS_RD: begin
            if (mv_ff > idx_ff + ONE) begin
               seg_rd_en = 1'b1;
               seg_rd_addr = IW'(mv_ff - ONE);
               state_in = ST_INS_WR;
            end else begin
               seg_wr_en = 1'b1;
               seg_wr_addr = IW'(idx_ff + ONE);
               seg_wr = '{empty: 1'b1, length: ent_len_ff - cnt_ff,
                          start: start_sum[bra_pkg::OFS_W-1:0]};
               seg_total_in = seg_total_ff + ONE;
               if (idx_ff + ONE < seg_total_ff && fl_total_ff < SEG_LIMIT) begin
                  fl_wr_en = 1'b1;
                  fl_wr_addr = fl_total_ff[IW-1:0];
                  fl_wr_data = start_sum[bra_pkg::OFS_W-1:0];
                  fl_total_in = fl_total_ff + ONE;
               end
               state_in = ST_ALLOC_FIN;
            end
         end
         ST_INS_WR: begin
            seg_wr_en = 1'b1;
            seg_wr_addr = mv_ff[IW-1:0];
            seg_wr = seg_rd;
            mv_in = mv_ff - ONE;
            state_in = ST_INS_RD;
         end
         ST_ALLOC_FIN: begin
            seg_wr_en = 1'b1;
            seg_wr_addr = idx_ff[IW-1:0];
            seg_wr = '{empty: 1'b0, length: cnt_ff, start: ent_start_ff};
            free_in = free_ff - cnt_ff;
            used_in = used_ff + cnt_ff;
            offset_in = ent_start_ff;
            state_in = ST_TAIL_RD;
         end
         // Release: the offset must start a used segment
         ST_REL_TEST: begin
            if (!hit_ff || ent_empty_ff) begin
               status_in = bra_pkg::STATUS_INVALID;
               state_in = ST_TAIL_RD;
            end else begin
               rcount_in = ent_len_ff;
               cur_start_in = ent_start_ff;
               cur_len_in = ent_len_ff;
               if (idx_ff != '0) begin
                  seg_rd_en = 1'b1;
                  seg_rd_addr = IW'(idx_ff - ONE);
                  state_in = ST_REL_PREV;
               end else begin
                  state_in = ST_NEXT_RD;
               end
            end
         end
         // Merge into an empty left neighbour
         ST_REL_PREV: begin
            if (seg_rd.empty) begin
               cur_start_in = seg_rd.start;
               cur_len_in = seg_rd.length + cur_len_ff;
               mv_in = idx_ff;
               idx_in = idx_ff - ONE;
               ret_in = ST_NEXT_RD;
               state_in = ST_SR_RD;
            end else begin
               state_in = ST_NEXT_RD;
            end
         end
         ST_NEXT_RD: begin
            if (idx_ff + ONE < seg_total_ff) begin
               seg_rd_en = 1'b1;
               seg_rd_addr = IW'(idx_ff + ONE);
               state_in = ST_NEXT;
            end else begin
               state_in = ST_SELF;
            end
         end
         // Absorb an empty right neighbour and drop it from the free list
         ST_NEXT: begin
            if (seg_rd.empty) begin
               ent_len_in = seg_rd.length;
               key_in = seg_rd.start;
               scan_in = '0;
               ret_in = ST_NEXT_FL;
               state_in = ST_FF_RD;
            end else begin
               state_in = ST_SELF;
            end
         end
         ST_NEXT_FL: begin
            if (hit_ff) begin
               mv_in = pos_ff;
               ret_in = ST_NEXT_RM;
               state_in = ST_FR_RD;
            end else begin
               state_in = ST_NEXT_RM;
            end
         end
         ST_NEXT_RM: begin
            cur_len_in = cur_len_ff + ent_len_ff;
            mv_in = idx_ff + ONE;
            ret_in = ST_SELF;
            state_in = ST_SR_RD;
         end
         ST_SELF: begin
            key_in = cur_start_ff;
            scan_in = '0;
            ret_in = ST_SELF_FL;
            state_in = ST_FF_RD;
         end
         // Keep the merged segment on the free list unless it is the tail
         ST_SELF_FL: begin
            if (idx_ff + ONE >= seg_total_ff) begin
               if (hit_ff) begin
                  mv_in = pos_ff;
                  ret_in = ST_REL_FIN;
                  state_in = ST_FR_RD;
               end else begin
                  state_in = ST_REL_FIN;
               end
            end else begin
               if (!hit_ff && fl_total_ff < SEG_LIMIT) begin
                  fl_wr_en = 1'b1;
                  fl_wr_addr = fl_total_ff[IW-1:0];
                  fl_wr_data = cur_start_ff;
                  fl_total_in = fl_total_ff + ONE;
               end
               state_in = ST_REL_FIN;
            end
         end
         ST_REL_FIN: begin
            seg_wr_en = 1'b1;
            seg_wr_addr = idx_ff[IW-1:0];
            seg_wr = '{empty: 1'b1, length: cur_len_ff, start: cur_start_ff};
            used_in = used_ff - rcount_ff;
            free_in = free_ff + rcount_ff;
            state_in = ST_TAIL_RD;
         end
         // Fetch the tail for the free-at-end figure
         ST_TAIL_RD: begin
            seg_rd_en = 1'b1;
            seg_rd_addr = last[IW-1:0];
            state_in = ST_TAIL;
         end
         ST_TAIL: begin
            tail_in = seg_rd.empty ? seg_rd.length : '0;
            state_in = ST_DONE;
         end
         // Hold the result until the output register frees
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         // Find a segment by start offset
         ST_SF_RD: begin
            if (scan_ff >= seg_total_ff) begin
               hit_in = 1'b0;
               state_in = ret_ff;
            end else begin
               seg_rd_en = 1'b1;
               seg_rd_addr = scan_ff[IW-1:0];
               state_in = ST_SF_CMP;
            end
         end
         ST_SF_CMP: begin
            if (seg_rd.start == key_ff) begin
               hit_in = 1'b1;
               idx_in = scan_ff;
               ent_start_in = seg_rd.start;
               ent_len_in = seg_rd.length;
               ent_empty_in = seg_rd.empty;
               state_in = ret_ff;
            end else begin
               scan_in = scan_ff + ONE;
               state_in = ST_SF_RD;
            end
         end
         // Find a free-list entry by start offset
         ST_FF_RD: begin
            if (scan_ff >= fl_total_ff) begin
               hit_in = 1'b0;
               state_in = ret_ff;
            end else begin
               fl_rd_en = 1'b1;
               fl_rd_addr = scan_ff[IW-1:0];
               state_in = ST_FF_CMP;
            end
         end
         ST_FF_CMP: begin
            if (fl_rd_data == key_ff) begin
               hit_in = 1'b1;
               pos_in = scan_ff;
               state_in = ret_ff;
            end else begin
               scan_in = scan_ff + ONE;
               state_in = ST_FF_RD;
            end
         end
         // Remove a segment, shifting the later ones down
         ST_SR_RD: begin
            if (mv_ff + ONE >= seg_total_ff) begin
               seg_total_in = seg_total_ff - ONE;
               state_in = ret_ff;
            end else begin
               seg_rd_en = 1'b1;
               seg_rd_addr = IW'(mv_ff + ONE);
               state_in = ST_SR_WR;
            end
         end
         ST_SR_WR: begin
            seg_wr_en = 1'b1;
            seg_wr_addr = mv_ff[IW-1:0];
            seg_wr = seg_rd;
            mv_in = mv_ff + ONE;
            state_in = ST_SR_RD;
         end
         // Remove a free-list entry, shifting the later ones down
         ST_FR_RD: begin
            if (mv_ff + ONE >= fl_total_ff) begin
               fl_total_in = fl_total_ff - ONE;
               state_in = ret_ff;
            end else begin
               fl_rd_en = 1'b1;
               fl_rd_addr = IW'(mv_ff + ONE);
               state_in = ST_FR_WR;
            end
         end
         ST_FR_WR: begin
            fl_wr_en = 1'b1;
            fl_wr_addr = mv_ff[IW-1:0];
            fl_wr_data = fl_rd_data;
            mv_in = mv_ff + ONE;
            state_in = ST_FR_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ret_ff <= ST_IDLE;
         cap_ff <= bra_pkg::CAPACITY_RESET;
         seg_total_ff <= ONE;
         fl_total_ff <= '0;
         applied_ff <= (bra_pkg::CAPACITY_RESET > bra_pkg::MAX_ELEMENTS) ?
                       bra_pkg::MAX_ELEMENTS : bra_pkg::CAPACITY_RESET;
         used_ff <= '0;
         free_ff <= (bra_pkg::CAPACITY_RESET > bra_pkg::MAX_ELEMENTS) ?
                    bra_pkg::MAX_ELEMENTS : bra_pkg::CAPACITY_RESET;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         cap_ff <= cap_in;
         seg_total_ff <= seg_total_in;
         fl_total_ff <= fl_total_in;
         applied_ff <= applied_in;
         used_ff <= used_in;
         free_ff <= free_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rcount_ff <= rcount_in;
      key_ff <= key_in;
      scan_ff <= scan_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      f_ff <= f_in;
      mv_ff <= mv_in;
      hit_ff <= hit_in;
      flhit_ff <= flhit_in;
      ent_start_ff <= ent_start_in;
      ent_len_ff <= ent_len_in;
      ent_empty_ff <= ent_empty_in;
      cur_start_ff <= cur_start_in;
      cur_len_ff <= cur_len_in;
      status_ff <= status_in;
      offset_ff <= offset_in;
      tail_ff <= tail_in;
   end

endmodule

// ===== rtl/core/block_range_allocator.sv =====
// Top level of the block range allocator: stream ports, output register,
// sequencer and the two table memories. Depends on bra_pkg, bra_ram, bra_ctrl.
//
// First-fit allocator over up to 4096 elements, kept as an address-ordered
// segment table plus a free list of non-tail empty segments, both in
// single-port-read memories with registered read data. One item is worked
// at a time; each gives exactly one result. How long an item takes depends on
// the sequencer's walks over the two memories: it visits free-list entries in
// turn, looks up the segment of each visited entry by a scan of the table, and
// shifts entries when a segment is inserted or removed. After reset the
// sequencer lays down the first segment before the first item is taken.
// The next item is accepted while the last result still waits on rsp_tready.
module block_range_allocator #(
   parameter int MAX_SEGMENTS = bra_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bra_pkg::LEN_W-1:0]        csr_wdata,   // capacity
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // request_count [12:0], release_offset [24:13], zero fill
   input  logic [bra_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status [2:0], range_offset [14:3], used_total [27:15],
   // free_total [40:28], free_at_end [53:41], zero fill
   output logic [bra_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int RES_W = $bits(bra_pkg::result_type);

   logic res_valid, res_ready;
   bra_pkg::result_type res;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0] rsp_data_ff, rsp_data_in;

   logic seg_wr_en, seg_rd_en, fl_wr_en, fl_rd_en;
   logic [IW-1:0] seg_wr_addr, seg_rd_addr, fl_wr_addr, fl_rd_addr;
   logic [bra_pkg::SEG_W-1:0] seg_wr_data, seg_rd_data;
   logic [bra_pkg::OFS_W-1:0] fl_wr_data, fl_rd_data;

   bra_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_count   (req_tdata[12:0]),
      .req_offset  (req_tdata[24:13]),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .seg_wr_en   (seg_wr_en),
      .seg_wr_addr (seg_wr_addr),
      .seg_wr_data (seg_wr_data),
      .seg_rd_en   (seg_rd_en),
      .seg_rd_addr (seg_rd_addr),
      .seg_rd_data (seg_rd_data),
      .fl_wr_en    (fl_wr_en),
      .fl_wr_addr  (fl_wr_addr),
      .fl_wr_data  (fl_wr_data),
      .fl_rd_en    (fl_rd_en),
      .fl_rd_addr  (fl_rd_addr),
      .fl_rd_data  (fl_rd_data)
   );

   bra_ram #(.WIDTH(bra_pkg::SEG_W), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
      .clock   (clock),
      .wr_en   (seg_wr_en),
      .wr_addr (seg_wr_addr),
      .wr_data (seg_wr_data),
      .rd_en   (seg_rd_en),
      .rd_addr (seg_rd_addr),
      .rd_data (seg_rd_data)
   );

   bra_ram #(.WIDTH(bra_pkg::OFS_W), .DEPTH(MAX_SEGMENTS)) u_fl_ram (
      .clock   (clock),
      .wr_en   (fl_wr_en),
      .wr_addr (fl_wr_addr),
      .wr_data (fl_wr_data),
      .rd_en   (fl_rd_en),
      .rd_addr (fl_rd_addr),
      .rd_data (fl_rd_data)
   );

   // Output register: load when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(bra_pkg::RSP_DATA_W - RES_W){1'b0}}, rsp_data_ff};

endmodule

// ===== rtl/core/bra_checker.sv =====
// Port-level checks for the block range allocator, bound to the top level.
// Depends on bra_pkg and block_range_allocator.
module bra_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bra_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // Hold a stalled item
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // Used and free together never exceed the space
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[27:15]} + {1'b0, rsp_tdata[40:28]})
                     <= {1'b0, bra_pkg::MAX_ELEMENTS})
      else $error("used plus free exceeds the space");

   // A failed request grants no range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != bra_pkg::STATUS_OK |-> rsp_tdata[14:3] == '0)
      else $error("offset given on a failed request");

   // The trailing free run is part of the free total
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[53:41] <= rsp_tdata[40:28])
      else $error("free at end exceeds free total");

endmodule

bind block_range_allocator bra_checker u_bra_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for block_range_allocator: stream requests in,
// results compared field by field against a first-fit segment table model.
// Depends on bra_pkg and the block_range_allocator RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSEG = 64;
   localparam int STALL_LIMIT = 60000;
   localparam int LEN_W = bra_pkg::LEN_W;
   localparam int OFS_W = bra_pkg::OFS_W;
   localparam int STATUS_W = bra_pkg::STATUS_W;
   localparam int REQ_DATA_W = bra_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = bra_pkg::RSP_DATA_W;

   typedef struct {
      logic                 op;
      logic [LEN_W-1:0]     count;
      logic [OFS_W-1:0]     offset;
      bra_pkg::result_type  outcome;
   } alloc_req_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [LEN_W-1:0]      csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Allocator model state
   int unsigned cap_reg;
   int unsigned seg_start [NSEG];
   int unsigned seg_len [NSEG];
   bit          seg_free [NSEG];
   int unsigned seg_cnt;
   int unsigned hole_list [NSEG];
   int unsigned hole_cnt;
   int unsigned applied;
   int unsigned used_cnt;
   int unsigned free_cnt;

   // Stimulus and checking stores
   alloc_req_type        pending_q[$];
   bra_pkg::result_type  outcome_q[$];
   int unsigned          live_ofs[$];
   alloc_req_type        cur;
   int unsigned          gap;
   int unsigned          idle_mode;
   int unsigned          n_sent;
   int unsigned          n_checked;
   int unsigned          n_errors;
   int unsigned          n_full;
   int unsigned          n_nospace;
   int unsigned          stall_cycles;

   block_range_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- model ----------------
   function automatic int unsigned eff_cap();
      return (cap_reg > 4096) ? 4096 : cap_reg;
   endfunction

   function automatic int find_seg(int unsigned s);
      for (int i = 0; i < seg_cnt; i++)
         if (seg_start[i] == s) return i;
      return -1;
   endfunction

   function automatic int find_hole(int unsigned s);
      for (int i = 0; i < hole_cnt; i++)
         if (hole_list[i] == s) return i;
      return -1;
   endfunction

   function automatic void seg_insert(int unsigned at, int unsigned s, int unsigned l, bit e);
      for (int i = seg_cnt; i > at; i--) begin
         seg_start[i] = seg_start[i-1];
         seg_len[i] = seg_len[i-1];
         seg_free[i] = seg_free[i-1];
      end
      seg_start[at] = s;
      seg_len[at] = l;
      seg_free[at] = e;
      seg_cnt++;
   endfunction

   function automatic void seg_remove(int unsigned at);
      for (int i = at; i + 1 < seg_cnt; i++) begin
         seg_start[i] = seg_start[i+1];
         seg_len[i] = seg_len[i+1];
         seg_free[i] = seg_free[i+1];
      end
      seg_cnt--;
   endfunction

   function automatic void hole_remove(int unsigned at);
      for (int i = at; i + 1 < hole_cnt; i++) hole_list[i] = hole_list[i+1];
      hole_cnt--;
   endfunction

   function automatic void model_reset();
      cap_reg = bra_pkg::CAPACITY_RESET;
      applied = eff_cap();
      seg_start[0] = 0;
      seg_len[0] = applied;
      seg_free[0] = 1'b1;
      seg_cnt = 1;
      hole_cnt = 0;
      used_cnt = 0;
      free_cnt = applied;
   endfunction

   function automatic logic [STATUS_W-1:0] model_allocate(int unsigned cnt,
                                                        output int unsigned ofs);
      int unsigned c;
      int unsigned last;
      int unsigned idx;
      int unsigned l;
      int          hpos;
      int          i;
      bit          hit;
      bit          was_last;
      ofs = 0;
      c = eff_cap();
      hit = 0;
      hpos = -1;
      idx = 0;
      if (cnt == 0) return bra_pkg::STATUS_INVALID;
      if (c < applied) return bra_pkg::STATUS_SHRANK;
      if (c > applied) begin
         last = seg_cnt - 1;
         if (seg_free[last]) seg_len[last] += c - applied;
         else begin
            if (seg_cnt >= NSEG) return bra_pkg::STATUS_TABLE_FULL;
            seg_insert(seg_cnt, applied, c - applied, 1'b1);
         end
         free_cnt += c - applied;
         applied = c;
      end
      // first fit over the hole list, then the tail
      for (int f = 0; f < hole_cnt && !hit; f++) begin
         i = find_seg(hole_list[f]);
         if (i >= 0 && seg_len[i] >= cnt) begin
            idx = i;
            hpos = f;
            hit = 1;
         end
      end
      if (!hit) begin
         last = seg_cnt - 1;
         if (seg_free[last] && seg_len[last] >= cnt) begin
            idx = last;
            hit = 1;
         end
      end
      if (!hit) return bra_pkg::STATUS_NO_SPACE;
      l = seg_len[idx];
      if (l > cnt && seg_cnt >= NSEG) return bra_pkg::STATUS_TABLE_FULL;
      if (hpos >= 0) hole_remove(hpos);
      if (l > cnt) begin
         was_last = (idx + 1 >= seg_cnt);
         seg_insert(idx + 1, seg_start[idx] + cnt, l - cnt, 1'b1);
         if (!was_last) hole_list[hole_cnt++] = seg_start[idx] + cnt;
      end
      seg_len[idx] = cnt;
      seg_free[idx] = 1'b0;
      free_cnt -= cnt;
      used_cnt += cnt;
      ofs = seg_start[idx];
      return bra_pkg::STATUS_OK;
   endfunction

   function automatic logic [STATUS_W-1:0] model_release(int unsigned ofs);
      int          pos;
      int unsigned idx;
      int unsigned cnt;
      int          p;
      pos = find_seg(ofs);
      if (pos < 0) return bra_pkg::STATUS_INVALID;
      if (seg_free[pos]) return bra_pkg::STATUS_INVALID;
      idx = pos;
      cnt = seg_len[idx];
      seg_free[idx] = 1'b1;
      // coalesce with the empty segment below
      if (idx > 0 && seg_free[idx-1]) begin
         seg_len[idx-1] += seg_len[idx];
         seg_remove(idx);
         idx--;
      end
      // coalesce with the empty segment above
      if (idx + 1 < seg_cnt && seg_free[idx+1]) begin
         p = find_hole(seg_start[idx+1]);
         if (p >= 0) hole_remove(p);
         seg_len[idx] += seg_len[idx+1];
         seg_remove(idx + 1);
      end
      p = find_hole(seg_start[idx]);
      if (idx + 1 >= seg_cnt) begin
         if (p >= 0) hole_remove(p);
      end else if (p < 0) begin
         hole_list[hole_cnt++] = seg_start[idx];
      end
      used_cnt -= cnt;
      free_cnt += cnt;
      return bra_pkg::STATUS_OK;
   endfunction

   // Predict the outcome of one item and queue it for the driver
   task automatic queue_item(logic op, int unsigned cnt, int unsigned ofs);
      alloc_req_type it;
      int unsigned   got;
      int unsigned   last;
      it.op = op;
      it.count = LEN_W'(cnt);
      it.offset = OFS_W'(ofs);
      got = 0;
      if (op == bra_pkg::OP_ALLOCATE) it.outcome.status = model_allocate(cnt, got);
      else it.outcome.status = model_release(ofs);
      if (it.outcome.status != bra_pkg::STATUS_OK) got = 0;
      if (op == bra_pkg::OP_ALLOCATE && it.outcome.status == bra_pkg::STATUS_OK)
         live_ofs.push_back(got);
      if (it.outcome.status == bra_pkg::STATUS_TABLE_FULL) n_full++;
      if (it.outcome.status == bra_pkg::STATUS_NO_SPACE) n_nospace++;
      last = seg_cnt - 1;
      it.outcome.range_offset = OFS_W'(got);
      it.outcome.used_total = LEN_W'(used_cnt);
      it.outcome.free_total = LEN_W'(free_cnt);
      it.outcome.free_at_end = LEN_W'(seg_free[last] ? seg_len[last] : 0);
      pending_q.push_back(it);
   endtask

   // Release a live range, chosen at random
   task automatic release_live();
      int unsigned k;
      int unsigned o;
      k = $urandom_range(0, live_ofs.size() - 1);
      o = live_ofs[k];
      live_ofs.delete(k);
      queue_item(bra_pkg::OP_RELEASE, 0, o);
   endtask

   task automatic random_items(int unsigned n);
      int unsigned r;
      int unsigned sz;
      for (int j = 0; j < n; j++) begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            // run of unit allocates to fill the segment table
            for (int k = 0; k < 66; k++) queue_item(bra_pkg::OP_ALLOCATE, 1, 0);
            j += 65;
         end else if (r < 50 || live_ofs.size() == 0) begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4096)
                                             : $urandom_range(1, 96);
            queue_item(bra_pkg::OP_ALLOCATE, sz, 0);
         end else if (r < 92) begin
            release_live();
         end else begin
            // stray or repeated offsets
            queue_item(bra_pkg::OP_RELEASE, 0, $urandom_range(0, 4095));
         end
         // keep the pool from clogging
         if (live_ofs.size() > 50)
            while (live_ofs.size() > 20) begin
               release_live();
               j++;
            end
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_q.size() != 0 || req_tvalid || outcome_q.size() != 0);
   endtask

   task automatic write_capacity(int unsigned v);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= LEN_W'(v);
      @(posedge clock);
      csr_we <= 1'b0;
      cap_reg = v & 13'h1fff;
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (idle_mode == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      logic busy;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap = 0;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            outcome_q.push_back(cur.outcome);
            n_sent++;
            busy = 1'b0;
         end
         if (!busy) begin
            if (gap > 0) gap--;
            else if (pending_q.size() > 0) begin
               cur = pending_q.pop_front();
               req_tdata <= {7'b0, cur.offset, cur.count};
               req_tuser <= cur.op;
               busy = 1'b1;
               gap = pick_gap();
            end
         end
         if (($urandom_range(0, 59)) == 0) idle_mode = $urandom_range(0, 2);
         req_tvalid <= busy;
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      bra_pkg::result_type got;
      bra_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(bra_pkg::result_type)-1:0];
            n_checked++;
            if (outcome_q.size() == 0) begin
               n_errors++;
               if (n_errors <= 10) $display("unexpected result %p", got);
            end else begin
               want = outcome_q.pop_front();
               if (got.status !== want.status || got.range_offset !== want.range_offset ||
                   got.used_total !== want.used_total ||
                   got.free_total !== want.free_total ||
                   got.free_at_end !== want.free_at_end) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("mismatch at result %0d: expected %p, got %p",
                              n_checked, want, got);
               end
            end
         end
         rsp_tready <= (idle_mode == 0) ? 1'b1 : (pick_gap() == 0);
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------- sequence ----------------
   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= bra_pkg::OP_ALLOCATE;
      rsp_tready <= 1'b0;
      stall_cycles = 0;
      idle_mode = 1;
      n_sent = 0;
      n_checked = 0;
      n_errors = 0;
      n_full = 0;
      n_nospace = 0;
      model_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // oversize capacity acts as the maximum
      write_capacity(8191);

      // directed: zero count, whole space, no space, double and stray release,
      // merge with both neighbours empty, merge into the tail
      queue_item(bra_pkg::OP_ALLOCATE, 0, 0);
      queue_item(bra_pkg::OP_ALLOCATE, 4096, 0);
      queue_item(bra_pkg::OP_ALLOCATE, 1, 0);
      queue_item(bra_pkg::OP_RELEASE, 0, 0);
      queue_item(bra_pkg::OP_RELEASE, 0, 0);
      queue_item(bra_pkg::OP_RELEASE, 0, 4095);
      queue_item(bra_pkg::OP_ALLOCATE, 10, 0);
      queue_item(bra_pkg::OP_ALLOCATE, 10, 0);
      queue_item(bra_pkg::OP_ALLOCATE, 10, 0);
      queue_item(bra_pkg::OP_ALLOCATE, 10, 0);
      queue_item(bra_pkg::OP_RELEASE, 0, 0);
      queue_item(bra_pkg::OP_RELEASE, 0, 20);
      queue_item(bra_pkg::OP_ALLOCATE, 4, 0);
      queue_item(bra_pkg::OP_RELEASE, 0, 0);
      queue_item(bra_pkg::OP_RELEASE, 0, 10);
      queue_item(bra_pkg::OP_RELEASE, 0, 30);
      queue_item(bra_pkg::OP_ALLOCATE, 4096, 0);
      queue_item(bra_pkg::OP_RELEASE, 0, 0);
      live_ofs.delete();

      random_items(300);

      // shrink: allocates refused, releases still honoured
      write_capacity(1);
      for (int j = 0; j < 30; j++) begin
         if (live_ofs.size() > 0 && $urandom_range(0, 1)) release_live();
         else queue_item(bra_pkg::OP_ALLOCATE, $urandom_range(0, 4096), 0);
      end

      write_capacity(4096);
      random_items(260);

      wait_idle();
      repeat (50) @(posedge clock);
      $display("%0d items sent, %0d results checked over capacities 8191, 1 and 4096",
               n_sent, n_checked);
      $display("%0d table-full and %0d no-space outcomes seen", n_full, n_nospace);
      if (n_errors == 0 && outcome_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/bra_pkg.sv
rtl/core/bra_ram.sv
rtl/core/bra_ctrl.sv
rtl/core/block_range_allocator.sv
rtl/core/bra_checker.sv
tb/sv/tb.sv
